// ===== hdl/cmps_pkg.sv =====
// Package for the Catmull-Rom path sampler: payload and command types,
// controller state codes and the reciprocal tables used for the t step.
// Depends on nothing.
package cmps_pkg;

    localparam int unsigned PT_WIDTH   = 24;
    localparam int unsigned OUT_WIDTH  = 28;
    localparam int unsigned SEG_WIDTH  = 16;
    localparam int unsigned IDX_WIDTH  = 5;
    localparam int unsigned F_WIDTH    = 6;
    localparam int unsigned T_WIDTH    = 16;

    typedef struct packed {
        logic signed [PT_WIDTH-1:0] point_x;
        logic signed [PT_WIDTH-1:0] point_y;
        logic                       final_point;
    } point_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] sample_x;
        logic signed [OUT_WIDTH-1:0] sample_y;
        logic [SEG_WIDTH-1:0]        segment_index;
        logic [IDX_WIDTH-1:0]        sample_index;
        logic                        last_of_run;
        logic                        route_too_short;
    } sample_t;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_CUBIC,
        KIND_END
    } seg_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF,
        S_POW,
        S_CUBE,
        S_MUL,
        S_SUM,
        S_OUT,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic               load_point;
        logic               shift;
        logic               coef_load;
        seg_kind_t          kind;
        logic               t_clear;
        logic               t_step;
        logic               pow;
        logic               cube;
        logic               mul;
        logic               sum;
        logic               err_load;
        logic [F_WIDTH-1:0] f;
    } dp_cmd_t;

    // Quotient of 65536 by F, F from 2 to 32; any other F gives 0.
    function automatic logic [T_WIDTH-1:0] recip_quot(input logic [F_WIDTH-1:0] f);
        logic [T_WIDTH-1:0] q;
        unique case (f)
            6'd2:  q = 16'd32768;
            6'd3:  q = 16'd21845;
            6'd4:  q = 16'd16384;
            6'd5:  q = 16'd13107;
            6'd6:  q = 16'd10922;
            6'd7:  q = 16'd9362;
            6'd8:  q = 16'd8192;
            6'd9:  q = 16'd7281;
            6'd10: q = 16'd6553;
            6'd11: q = 16'd5957;
            6'd12: q = 16'd5461;
            6'd13: q = 16'd5041;
            6'd14: q = 16'd4681;
            6'd15: q = 16'd4369;
            6'd16: q = 16'd4096;
            6'd17: q = 16'd3855;
            6'd18: q = 16'd3640;
            6'd19: q = 16'd3449;
            6'd20: q = 16'd3276;
            6'd21: q = 16'd3120;
            6'd22: q = 16'd2978;
            6'd23: q = 16'd2849;
            6'd24: q = 16'd2730;
            6'd25: q = 16'd2621;
            6'd26: q = 16'd2520;
            6'd27: q = 16'd2427;
            6'd28: q = 16'd2340;
            6'd29: q = 16'd2259;
            6'd30: q = 16'd2184;
            6'd31: q = 16'd2114;
            6'd32: q = 16'd2048;
            default: q = '0;
        endcase
        return q;
    endfunction

    // Remainder of 65536 by F, F from 1 to 32.
    function automatic logic [F_WIDTH-1:0] recip_rem(input logic [F_WIDTH-1:0] f);
        logic [F_WIDTH-1:0] r;
        unique case (f)
            6'd3, 6'd5, 6'd15, 6'd17: r = 6'd1;
            6'd7, 6'd14, 6'd31:       r = 6'd2;
            6'd13:                    r = 6'd3;
            6'd6, 6'd12:              r = 6'd4;
            6'd19:                    r = 6'd5;
            6'd10:                    r = 6'd6;
            6'd9, 6'd27:              r = 6'd7;
            6'd11, 6'd23:             r = 6'd9;
            6'd25:                    r = 6'd11;
            6'd18, 6'd20, 6'd21, 6'd24, 6'd26, 6'd28, 6'd30: r = 6'd16;
            6'd22:                    r = 6'd20;
            6'd29:                    r = 6'd25;
            default:                  r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/cmps_stream_if.sv =====
// Valid/ready channel interfaces for waypoint words and sample words.
// Depends on cmps_pkg.
interface cmps_point_if;
    logic              valid;
    logic              ready;
    cmps_pkg::point_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cmps_sample_if;
    logic              valid;
    logic              ready;
    cmps_pkg::sample_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cmps_datapath.sv =====
// Datapath: waypoint window, segment coefficients, t generator, powers of t,
// products and the saturating sample sum. Depends on cmps_pkg.
module cmps_datapath #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cmps_pkg::point_t                         in_point,
    input  cmps_pkg::dp_cmd_t                        cmd,
    output logic signed [cmps_pkg::OUT_WIDTH-1:0]    sample_x,
    output logic signed [cmps_pkg::OUT_WIDTH-1:0]    sample_y
);
    import cmps_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int CFW = CW + 4;
    localparam int PW  = CFW + 17;
    localparam int SW  = CFW + 2;
    localparam int WW  = (SW > 28) ? SW : 28;
    localparam logic signed [WW-1:0] OMAX = WW'(134217727);
    localparam logic signed [WW-1:0] OMIN = -WW'(134217728);

    logic signed [CW-1:0]  rec_reg [2][3];
    logic signed [CW-1:0]  q_reg [2];
    logic signed [CW-1:0]  q_in [2];
    logic signed [CFW-1:0] a_reg [2], b_reg [2], c_reg [2], d_reg [2];
    logic signed [CFW-1:0] a_next [2], b_next [2], c_next [2], d_next [2];
    logic signed [CFW-1:0] ta_reg [2], tb_reg [2], tc_reg [2];
    logic signed [OUT_WIDTH-1:0] s_reg [2];
    logic signed [OUT_WIDTH-1:0] s_next [2];
    logic [T_WIDTH-1:0] t_reg, t2_reg, t3_reg, t_next;
    logic [F_WIDTH-1:0] r_reg, r_next;
    logic [F_WIDTH:0]   r_sum;
    logic [2*T_WIDTH-1:0] tt, t2t;
    logic [CW+PT_WIDTH-1:0] wide_x, wide_y;

    assign wide_x = {{CW{1'b0}}, in_point.point_x};
    assign wide_y = {{CW{1'b0}}, in_point.point_y};
    assign q_in[0] = wide_x[CW-1:0];
    assign q_in[1] = wide_y[CW-1:0];

    always_comb
    begin
        logic signed [CFW-1:0] p0, p1, p2, p3;
        for (int ax = 0; ax < 2; ax++)
        begin
            p0 = CFW'(rec_reg[ax][0]);
            p1 = CFW'(rec_reg[ax][1]);
            p2 = CFW'(rec_reg[ax][2]);
            p3 = CFW'(q_reg[ax]);
            unique case (cmd.kind)
                KIND_CUBIC:
                begin
                    a_next[ax] = CFW'(-p0 + 3 * p1 - 3 * p2 + p3);
                    b_next[ax] = CFW'(2 * p0 - 5 * p1 + 4 * p2 - p3);
                    c_next[ax] = p2 - p0;
                    d_next[ax] = CFW'(2 * p1);
                end
                KIND_START:
                begin
                    a_next[ax] = '0;
                    b_next[ax] = CFW'(p1 - 2 * p2 + p3);
                    c_next[ax] = CFW'(-3 * p1 + 4 * p2 - p3);
                    d_next[ax] = CFW'(2 * p1);
                end
                default:
                begin
                    a_next[ax] = '0;
                    b_next[ax] = CFW'(p1 - 2 * p2 + p3);
                    c_next[ax] = p3 - p1;
                    d_next[ax] = CFW'(2 * p2);
                end
            endcase
        end
    end

    always_comb
    begin
        r_sum = {1'b0, r_reg} + {1'b0, recip_rem(cmd.f)};
        if (r_sum >= {1'b0, cmd.f})
        begin
            r_next = F_WIDTH'(r_sum - {1'b0, cmd.f});
            t_next = t_reg + recip_quot(cmd.f) + T_WIDTH'(1);
        end
        else
        begin
            r_next = r_sum[F_WIDTH-1:0];
            t_next = t_reg + recip_quot(cmd.f);
        end
    end

    assign tt  = t_reg * t_reg;
    assign t2t = t2_reg * t_reg;

    always_comb
    begin
        logic signed [SW-1:0] s;
        logic signed [WW-1:0] h;
        for (int ax = 0; ax < 2; ax++)
        begin
            s = SW'(ta_reg[ax]) + SW'(tb_reg[ax]) + SW'(tc_reg[ax]) + SW'(d_reg[ax]);
            h = WW'(s >>> 1);
            if (h > OMAX)
                s_next[ax] = OUT_WIDTH'(OMAX);
            else if (h < OMIN)
                s_next[ax] = OUT_WIDTH'(OMIN);
            else
                s_next[ax] = OUT_WIDTH'(h);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ax = 0; ax < 2; ax++)
                for (int j = 0; j < 3; j++)
                    rec_reg[ax][j] <= '0;
        end
        else if (cmd.shift)
        begin
            for (int ax = 0; ax < 2; ax++)
            begin
                rec_reg[ax][0] <= rec_reg[ax][1];
                rec_reg[ax][1] <= rec_reg[ax][2];
                rec_reg[ax][2] <= q_reg[ax];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [PW-1:0] pa, pb, pc;
        if (cmd.load_point)
        begin
            q_reg[0] <= q_in[0];
            q_reg[1] <= q_in[1];
        end
        if (cmd.coef_load)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
        if (cmd.t_clear)
        begin
            t_reg <= '0;
            r_reg <= '0;
        end
        else if (cmd.t_step)
        begin
            t_reg <= t_next;
            r_reg <= r_next;
        end
        if (cmd.pow)
            t2_reg <= tt[2*T_WIDTH-1:T_WIDTH];
        if (cmd.cube)
            t3_reg <= t2t[2*T_WIDTH-1:T_WIDTH];
        if (cmd.mul)
        begin
            for (int ax = 0; ax < 2; ax++)
            begin
                pa = a_reg[ax] * $signed({1'b0, t3_reg});
                pb = b_reg[ax] * $signed({1'b0, t2_reg});
                pc = c_reg[ax] * $signed({1'b0, t_reg});
                ta_reg[ax] <= CFW'(pa >>> 16);
                tb_reg[ax] <= CFW'(pb >>> 16);
                tc_reg[ax] <= CFW'(pc >>> 16);
            end
        end
        if (cmd.err_load)
        begin
            s_reg[0] <= '0;
            s_reg[1] <= '0;
        end
        else if (cmd.sum)
            s_reg <= s_next;
    end

    assign sample_x = s_reg[0];
    assign sample_y = s_reg[1];

endmodule

// ===== hdl/cmps_ctrl.sv =====
// Controller: sequences waypoint intake, segments and samples, and keeps the
// point count, segment and sample indexes and the F register. Uses cmps_pkg.
module cmps_ctrl #(
    parameter int MAX_SAMPLES = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cmps_pkg::F_WIDTH-1:0]      cfg_wr_data,
    input  logic                              in_valid,
    input  logic                              in_final,
    output logic                              in_ready,
    input  logic                              out_ready,
    output logic                              out_valid,
    output cmps_pkg::dp_cmd_t                 cmd,
    output logic [cmps_pkg::SEG_WIDTH-1:0]    segment_index,
    output logic [cmps_pkg::IDX_WIDTH-1:0]    sample_index,
    output logic                              last_of_run,
    output logic                              route_too_short
);
    import cmps_pkg::*;

    localparam logic [F_WIDTH-1:0] F_MAX = F_WIDTH'(MAX_SAMPLES);

    ctrl_state_t          state_reg, state_next;
    seg_kind_t            kind_reg, kind_next;
    logic [F_WIDTH-1:0]   cfg_reg, f_reg, f_next, f_eff;
    logic                 fin_reg, fin_next;
    logic [SEG_WIDTH-1:0] seen_reg, seen_next, seg_reg, seg_next;
    logic [IDX_WIDTH-1:0] idx_reg, idx_next;
    logic [SEG_WIDTH-1:0] oseg_reg, oseg_next;
    logic [IDX_WIDTH-1:0] oidx_reg, oidx_next;
    logic                 olast_reg, olast_next, oerr_reg, oerr_next;
    logic                 seg_done;

    always_comb
    begin
        if (cfg_reg == '0)
            f_eff = F_WIDTH'(1);
        else if (cfg_reg > F_MAX)
            f_eff = F_MAX;
        else
            f_eff = cfg_reg;
    end

    assign seg_done = ({1'b0, idx_reg} == f_reg - F_WIDTH'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_START;
            cfg_reg   <= F_WIDTH'(32);
            f_reg     <= F_WIDTH'(1);
            fin_reg   <= 1'b0;
            seen_reg  <= '0;
            seg_reg   <= '0;
            idx_reg   <= '0;
            oseg_reg  <= '0;
            oidx_reg  <= '0;
            olast_reg <= 1'b0;
            oerr_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            if (cfg_wr_en)
                cfg_reg <= cfg_wr_data;
            f_reg     <= f_next;
            fin_reg   <= fin_next;
            seen_reg  <= seen_next;
            seg_reg   <= seg_next;
            idx_reg   <= idx_next;
            oseg_reg  <= oseg_next;
            oidx_reg  <= oidx_next;
            olast_reg <= olast_next;
            oerr_reg  <= oerr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        f_next     = f_reg;
        fin_next   = fin_reg;
        seen_next  = seen_reg;
        seg_next   = seg_reg;
        idx_next   = idx_reg;
        oseg_next  = oseg_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        oerr_next  = oerr_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        cmd.f      = f_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_point = 1'b1;
                    fin_next = in_final;
                    f_next   = f_eff;
                    if (seen_reg < SEG_WIDTH'(2))
                    begin
                        if (in_final)
                        begin
                            cmd.err_load = 1'b1;
                            oseg_next  = '0;
                            oidx_next  = '0;
                            olast_next = 1'b1;
                            oerr_next  = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_FINISH;
                    end
                    else
                    begin
                        kind_next  = (seen_reg == SEG_WIDTH'(2)) ? KIND_START : KIND_CUBIC;
                        seg_next   = seen_reg - SEG_WIDTH'(2);
                        state_next = S_COEF;
                    end
                end
            end
            S_COEF:
            begin
                cmd.coef_load = 1'b1;
                cmd.t_clear   = 1'b1;
                idx_next      = '0;
                state_next    = S_POW;
            end
            S_POW:
            begin
                cmd.pow    = 1'b1;
                state_next = S_CUBE;
            end
            S_CUBE:
            begin
                cmd.cube   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                oseg_next  = seg_reg;
                oidx_next  = idx_reg;
                olast_next = seg_done && (kind_reg == KIND_END || !fin_reg);
                oerr_next  = 1'b0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (oerr_reg)
                    begin
                        seen_next  = '0;
                        state_next = S_IDLE;
                    end
                    else if (seg_done)
                    begin
                        if (kind_reg != KIND_END && fin_reg)
                        begin
                            kind_next  = KIND_END;
                            seg_next   = seen_reg - SEG_WIDTH'(1);
                            state_next = S_COEF;
                        end
                        else
                            state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_WIDTH'(1);
                        cmd.t_step = 1'b1;
                        state_next = S_POW;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.shift = 1'b1;
                if (fin_reg)
                    seen_next = '0;
                else if (seen_reg != '1)
                    seen_next = seen_reg + SEG_WIDTH'(1);
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign segment_index   = oseg_reg;
    assign sample_index    = oidx_reg;
    assign last_of_run     = olast_reg;
    assign route_too_short = oerr_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !oerr_reg) |-> ({1'b0, oidx_reg} < f_reg))
        else $error("sample index beyond samples per segment");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && olast_reg) |=>
            (state_reg == S_FINISH || state_reg == S_IDLE))
        else $error("work continued after last word of run");

    a_error_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && oerr_reg) |=> (seen_reg == '0))
        else $error("point count not cleared after short route");

endmodule

// ===== hdl/catmull_rom_path_sampler_unit.sv =====
// Each segment first loads its coefficients; each sample then passes the steps
// t squared, t cubed, products, sum and output, plus any output stall time.
// A waypoint with no samples goes through the finish step only. One waypoint
// is in work at a time.
// Reset (rst_n low, asynchronous) clears the point count and window; F is 32.
module catmull_rom_path_sampler_unit #(
    parameter int MAX_SAMPLES = 32,
    parameter int COORD_WIDTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [cmps_pkg::F_WIDTH-1:0] cfg_wr_data,
    cmps_point_if.sink                   in_pt,
    cmps_sample_if.source                out_smp
);
    import cmps_pkg::*;

    dp_cmd_t cmd;

    cmps_ctrl #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_pt.valid),
        .in_final        (in_pt.data.final_point),
        .in_ready        (in_pt.ready),
        .out_ready       (out_smp.ready),
        .out_valid       (out_smp.valid),
        .cmd             (cmd),
        .segment_index   (out_smp.data.segment_index),
        .sample_index    (out_smp.data.sample_index),
        .last_of_run     (out_smp.data.last_of_run),
        .route_too_short (out_smp.data.route_too_short)
    );

    cmps_datapath #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_point (in_pt.data),
        .cmd      (cmd),
        .sample_x (out_smp.data.sample_x),
        .sample_y (out_smp.data.sample_y)
    );

endmodule
